// ----- src/srrw_pkg.sv -----
// Package for the selective-repeat receive window.
// Holds field widths, reset constants, the arrival class codes and the result struct.
// No dependencies.
package srrw_pkg;

  localparam int unsigned SEQ_W              = 32;
  localparam int unsigned SACK_W             = 32;
  localparam int unsigned WS_W               = 6;
  localparam int unsigned MAX_WINDOW_DEFAULT = 32;
  localparam logic [WS_W-1:0] WIN_LEN_RESET = 6'd32;

  typedef enum logic [1:0] {
    ARR_IN_ORDER  = 2'd0,
    ARR_AHEAD     = 2'd1,
    ARR_BEYOND    = 2'd2,
    ARR_DUPLICATE = 2'd3
  } arrival_e;

  typedef struct packed {
    logic              ack_valid;
    logic [SEQ_W-1:0]  ack_number;
    logic [SACK_W-1:0] sack_bits;
    logic              store_chunk;
    arrival_e          arrival_class;
  } srrw_result_t;

endpackage

// ----- src/srrw_window.sv -----
// Next-state and result logic of the receive window for one sequence number.
// Purely combinational; depends on srrw_pkg.
module srrw_window
  import srrw_pkg::*;
#(
  parameter int unsigned MaxWindow = MAX_WINDOW_DEFAULT
) (
  input  logic [WS_W-1:0]      win_len_i,
  input  logic [SEQ_W-1:0]     seq_i,
  input  logic [MaxWindow-1:0] map_i,
  input  logic [SEQ_W-1:0]     base_i,
  input  logic [MaxWindow-1:0] sack_i,
  output logic [MaxWindow-1:0] map_o,
  output logic [SEQ_W-1:0]     base_o,
  output logic [MaxWindow-1:0] sack_o,
  output srrw_result_t         result_o
);

  localparam int unsigned IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned RunW = $clog2(MaxWindow + 1);

  logic [WS_W-1:0]      win;
  logic [MaxWindow-1:0] mask;
  logic [MaxWindow-1:0] map_m;
  logic [MaxWindow-1:0] map_base;
  logic [MaxWindow:0]   ext;
  logic [MaxWindow:0]   first_zero;
  logic [RunW-1:0]      run;
  logic [SEQ_W-1:0]     win_end;
  logic [SEQ_W-1:0]     off;
  logic [SEQ_W-1:0]     off_m1;
  logic                 in_win;

  always_comb begin
    if (win_len_i == '0) begin
      win = WS_W'(1);
    end else if (win_len_i > WS_W'(MaxWindow)) begin
      win = WS_W'(MaxWindow);
    end else begin
      win = win_len_i;
    end
    for (int i = 0; i < MaxWindow; i++) begin
      mask[i] = (WS_W'(i) < win);
    end
  end

  // Slots outside a shrunk window are dropped on every item.
  assign map_m    = map_i & mask;
  assign map_base = map_m | MaxWindow'(1);

  // The lowest clear bit marks the end of the received run; bits above the
  // window are already clear, so the run never exceeds the window size.
  assign ext        = {1'b0, map_base};
  assign first_zero = ~ext & (ext + (MaxWindow + 1)'(1));

  always_comb begin
    run = '0;
    for (int i = 0; i <= MaxWindow; i++) begin
      if (first_zero[i]) run = run | RunW'(i);
    end
  end

  assign win_end = base_i + SEQ_W'(win) - SEQ_W'(1);
  assign in_win  = (seq_i <= win_end);
  assign off     = seq_i - base_i;
  assign off_m1  = off - SEQ_W'(1);

  always_comb begin
    map_o                  = map_m;
    base_o                 = base_i;
    sack_o                 = sack_i;
    result_o.ack_valid     = 1'b0;
    result_o.store_chunk   = 1'b0;
    result_o.arrival_class = ARR_DUPLICATE;
    if (seq_i == base_i) begin
      map_o                  = map_base >> run;
      base_o                 = base_i + SEQ_W'(run);
      sack_o                 = '0;
      result_o.ack_valid     = 1'b1;
      result_o.store_chunk   = 1'b1;
      result_o.arrival_class = ARR_IN_ORDER;
    end else if (seq_i > base_i) begin
      result_o.ack_valid = 1'b1;
      if (in_win) begin
        map_o                  = map_m | (MaxWindow'(1) << off[IdxW-1:0]);
        result_o.store_chunk   = 1'b1;
        result_o.arrival_class = ARR_AHEAD;
        if (win > WS_W'(1)) begin
          sack_o = sack_i | (MaxWindow'(1) << off_m1[IdxW-1:0]);
        end
      end else begin
        result_o.arrival_class = ARR_BEYOND;
      end
    end
    result_o.ack_number = base_o;
    result_o.sack_bits  = SACK_W'(sack_o);
  end

endmodule

// ----- src/selective_repeat_receive_window.sv -----
// Selective-repeat receive window: takes one sequence number per transfer and
// returns one acknowledgement result per transfer. Depends on srrw_pkg and srrw_window.
//
// One sequence number is taken every cycle while in_stall_o is low. The number
// lands in the input register (seq_q), and the window update (leading received
// run, slide, marking, selective-ack bit) is then settled into the state and
// result registers, which drive the outputs. The state update sets the rate of
// one item per clock while nothing stalls. A stall on the result side holds the
// result register and, once the input register is also full, stalls the input.
// The window length register may only be written while no transfer is in flight.
module selective_repeat_receive_window
  import srrw_pkg::*;
#(
  parameter int unsigned MaxWindow = MAX_WINDOW_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              win_len_we_i,
  input  logic [WS_W-1:0]   win_len_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SEQ_W-1:0]  seq_number_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              ack_valid_o,
  output logic [SEQ_W-1:0]  ack_number_o,
  output logic [SACK_W-1:0] sack_bits_o,
  output logic              store_chunk_o,
  output logic [1:0]        arrival_class_o
);

  logic [WS_W-1:0]      win_len_q;
  logic                 in_valid_q;
  logic [SEQ_W-1:0]     seq_q;
  logic [MaxWindow-1:0] map_q, map_d;
  logic [SEQ_W-1:0]     base_q, base_d;
  logic [MaxWindow-1:0] sack_q, sack_d;
  logic                 out_valid_q;
  srrw_result_t         res_q, res_d;
  logic                 out_load;

  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !out_load;

  srrw_window #(
    .MaxWindow(MaxWindow)
  ) u_window (
    .win_len_i(win_len_q),
    .seq_i    (seq_q),
    .map_i    (map_q),
    .base_i   (base_q),
    .sack_i   (sack_q),
    .map_o    (map_d),
    .base_o   (base_d),
    .sack_o   (sack_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= WIN_LEN_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      map_q       <= '0;
      base_q      <= '0;
      sack_q      <= '0;
    end else begin
      if (win_len_we_i) win_len_q <= win_len_i;
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
        map_q       <= map_d;
        base_q      <= base_d;
        sack_q      <= sack_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) seq_q <= seq_number_i;
    if (out_load) res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign ack_valid_o     = res_q.ack_valid;
  assign ack_number_o    = res_q.ack_number;
  assign sack_bits_o     = res_q.sack_bits;
  assign store_chunk_o   = res_q.store_chunk;
  assign arrival_class_o = res_q.arrival_class;

endmodule

// ----- src/srrw_checker.sv -----
// Port-level checks for the selective-repeat receive window, bound to the top level.
// Depends on srrw_pkg.
module srrw_checker
  import srrw_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              ack_valid_o,
  input logic [SEQ_W-1:0]  ack_number_o,
  input logic [SACK_W-1:0] sack_bits_o,
  input logic              store_chunk_o,
  input logic [1:0]        arrival_class_o
);

  logic [SEQ_W-1:0] last_ack_q;

  // The base only moves forward, and never by more than one full window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ack_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      last_ack_q <= ack_number_o;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ack_number_o)
      && $stable(sack_bits_o) && $stable(arrival_class_o))
    else $error("result changed while stalled");

  a_duplicate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arrival_class_o == ARR_DUPLICATE |-> !ack_valid_o && !store_chunk_o)
    else $error("duplicate acknowledged or stored");

  a_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arrival_class_o != ARR_DUPLICATE
      |-> ack_valid_o && (store_chunk_o == (arrival_class_o != ARR_BEYOND)))
    else $error("ack or store flag inconsistent with arrival class");

  a_in_order_clears_sack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arrival_class_o == ARR_IN_ORDER |-> sack_bits_o == '0)
    else $error("selective acks left after in-order arrival");

  a_base_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |-> (ack_number_o - last_ack_q) <= SEQ_W'(32))
    else $error("window base moved backward or too far");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .ack_valid_o    (ack_valid_o),
  .ack_number_o   (ack_number_o),
  .sack_bits_o    (sack_bits_o),
  .store_chunk_o  (store_chunk_o),
  .arrival_class_o(arrival_class_o)
);

// ----- bench/srrw_ack_checker.sv -----
// Checker for the selective-repeat receive window: watches both channels and the
// window length write port, predicts each acknowledgement and compares it field by field.
// Depends on srrw_pkg.
module srrw_ack_checker
  import srrw_pkg::*;
#(
  parameter int unsigned MaxWindow = MAX_WINDOW_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WS_W-1:0]     cfg_window_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [SEQ_W-1:0]    seq_number_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                ack_valid_i,
  input  logic [SEQ_W-1:0]    ack_number_i,
  input  logic [SACK_W-1:0]   sack_bits_i,
  input  logic                store_chunk_i,
  input  logic [1:0]          arrival_class_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output logic [SEQ_W-1:0]    base_o,
  output logic [3:0][31:0]    class_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [WS_W-1:0]   window_q;
  logic [31:0]       rcv_map;
  logic [SEQ_W-1:0]  base_q;
  logic [SACK_W-1:0] sack_q;
  srrw_result_t      ack_q[$];
  int unsigned       n_fail;
  int unsigned       cls_seen[4];

  // Applies one received sequence number to the window copy and returns the
  // acknowledgement the block should produce for it.
  function automatic srrw_result_t predict_ack(input logic [SEQ_W-1:0] seq);
    srrw_result_t r;
    int unsigned  w;
    int unsigned  run;
    logic [31:0]  mask;
    logic [31:0]  win_end;
    logic [31:0]  off;
    w = window_q;
    if (w < 1) w = 1;
    if (w > MaxWindow) w = MaxWindow;
    if (w > 32) w = 32;
    mask = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
    // A shrunk window forgets the slots that no longer fit.
    rcv_map &= mask;
    r = '0;
    if (seq == base_q) begin
      rcv_map[0] = 1'b1;
      run = 0;
      while (run < w && rcv_map[run]) run++;
      rcv_map = (run >= 32) ? '0 : ((rcv_map >> run) & mask);
      base_q = base_q + run;
      sack_q = '0;
      r.ack_valid = 1'b1;
      r.store_chunk = 1'b1;
      r.arrival_class = ARR_IN_ORDER;
    end else if (seq > base_q) begin
      // The window end wraps modulo 2^32, which can leave nothing in the window.
      win_end = base_q + w - 1;
      r.ack_valid = 1'b1;
      if (seq <= win_end) begin
        off = seq - base_q;
        rcv_map[off[4:0]] = 1'b1;
        r.store_chunk = 1'b1;
        r.arrival_class = ARR_AHEAD;
        if (w > 1) sack_q[off[4:0] - 5'd1] = 1'b1;
      end else begin
        r.arrival_class = ARR_BEYOND;
      end
    end else begin
      r.arrival_class = ARR_DUPLICATE;
    end
    r.ack_number = base_q;
    r.sack_bits = sack_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    srrw_result_t exp_r;
    if (!rst_ni) begin
      window_q = WIN_LEN_RESET;
      rcv_map = '0;
      base_q = '0;
      sack_q = '0;
      ack_q.delete();
      n_fail = 0;
      for (int k = 0; k < 4; k++) cls_seen[k] = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      base_o <= '0;
      class_cnt_o <= '0;
    end else begin
      if (cfg_we_i) window_q = cfg_window_i;
      if (in_valid_i && !in_stall_i) begin
        exp_r = predict_ack(seq_number_i);
        cls_seen[exp_r.arrival_class]++;
        ack_q.push_back(exp_r);
      end
      if (out_valid_i && !out_stall_i) begin
        if (ack_q.size() == 0) begin
          $error("unexpected result transfer: ack_number 0x%0h", ack_number_i);
          n_fail++;
        end else begin
          exp_r = ack_q.pop_front();
          check_field("ack_valid", exp_r.ack_valid, ack_valid_i);
          check_field("ack_number", exp_r.ack_number, ack_number_i);
          check_field("sack_bits", exp_r.sack_bits, sack_bits_i);
          check_field("store_chunk", exp_r.store_chunk, store_chunk_i);
          check_field("arrival_class", exp_r.arrival_class, arrival_class_i);
        end
      end
      fail_count_o <= n_fail;
      pending_o <= ack_q.size();
      base_o <= base_q;
      for (int k = 0; k < 4; k++) class_cnt_o[k] <= cls_seen[k];
    end
  end

endmodule

// ----- bench/tb_selective_repeat_receive_window.sv -----
// Top of the selective-repeat receive window testbench: clock, reset, window
// writes and sequence-number stimulus with random gaps and result stalls.
// Depends on srrw_pkg, selective_repeat_receive_window and srrw_ack_checker.
module tb_selective_repeat_receive_window
  import srrw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              win_len_we_i = 1'b0;
  logic [WS_W-1:0]   win_len_i = WIN_LEN_RESET;
  logic              in_valid_i = 1'b0;
  logic [SEQ_W-1:0]  seq_number_i = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic              ack_valid_o;
  logic [SEQ_W-1:0]  ack_number_o;
  logic [SACK_W-1:0] sack_bits_o;
  logic              store_chunk_o;
  logic [1:0]        arrival_class_o;

  int unsigned       fail_count;
  int unsigned       pending;
  logic [SEQ_W-1:0]  model_base;
  logic [3:0][31:0]  class_cnt;

  bit                idle_on = 1'b1;
  int unsigned       stall_left = 0;
  int unsigned       n_sent = 0;
  int unsigned       n_writes = 0;
  int unsigned       win_eff = 32;
  logic [SEQ_W-1:0]  cur_base = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  selective_repeat_receive_window u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .win_len_we_i    (win_len_we_i),
    .win_len_i       (win_len_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .seq_number_i    (seq_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ack_valid_o     (ack_valid_o),
    .ack_number_o    (ack_number_o),
    .sack_bits_o     (sack_bits_o),
    .store_chunk_o   (store_chunk_o),
    .arrival_class_o (arrival_class_o)
  );

  srrw_ack_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (win_len_we_i),
    .cfg_window_i   (win_len_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .seq_number_i   (seq_number_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ack_valid_i    (ack_valid_o),
    .ack_number_i   (ack_number_o),
    .sack_bits_i    (sack_bits_o),
    .store_chunk_i  (store_chunk_o),
    .arrival_class_i(arrival_class_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .base_o         (model_base),
    .class_cnt_o    (class_cnt)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
  endfunction

  function automatic logic [SEQ_W-1:0] noise_seq();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return cur_base - $urandom_range(1, 40);
      2: return cur_base + win_eff + $urandom_range(0, 100);
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  // Result-side stalls; a phase with idling off runs without any.
  always @(posedge clk_i) begin
    if (!rst_ni || !idle_on) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_seq(input logic [SEQ_W-1:0] s);
    int unsigned gap;
    gap = idle_on ? gap_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    seq_number_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  // Holds the sender off until every expected acknowledgement has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [WS_W-1:0] v);
    drain();
    win_len_we_i <= 1'b1;
    win_len_i <= v;
    @(posedge clk_i);
    win_len_we_i <= 1'b0;
    @(posedge clk_i);
    win_eff = (v == 0) ? 1 : (v > MAX_WINDOW_DEFAULT) ? MAX_WINDOW_DEFAULT : v;
    cur_base = model_base;
    n_writes++;
  endtask

  // Sends every slot of the current window once, usually shuffled, with some
  // retransmissions and stray numbers mixed in, so the base ends one window on.
  task automatic run_block(input bit noisy);
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] tmp;
    int unsigned      j;
    for (int unsigned i = 0; i < win_eff; i++) order.push_back(cur_base + i);
    if ($urandom_range(0, 3) != 0) begin
      for (int i = order.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    foreach (order[k]) begin
      if (noisy && $urandom_range(0, 7) == 0) send_seq(noise_seq());
      if (k > 0 && $urandom_range(0, 9) == 0) send_seq(order[$urandom_range(0, k - 1)]);
      send_seq(order[k]);
    end
    cur_base += win_eff;
  endtask

  initial begin : stimulus
    int unsigned      phase_idx;
    int unsigned      phase_end;
    logic [WS_W-1:0]  wval;
    logic [SEQ_W-1:0] b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window: in order, duplicate, ahead up to the last slot, beyond,
    // extreme numbers, then the gap filled so the base slides over a run.
    send_seq(32'd0);
    send_seq(32'd0);
    send_seq(32'd2);
    send_seq(32'd32);
    send_seq(32'd33);
    send_seq(32'hFFFF_FFFF);
    send_seq(32'h8000_0000);
    send_seq(32'd1);

    // Shrinking to four drops the far slot; then a whole window slides at once.
    set_window(6'd4);
    b = cur_base;
    send_seq(b + 2);
    send_seq(b + 1);
    send_seq(b + 3);
    send_seq(b + 4);
    send_seq(b);

    // Zero acts as a one-slot window.
    set_window(6'd0);
    b = cur_base;
    send_seq(b + 1);
    send_seq(b);
    send_seq(b - 1);

    // Oversized value acts as the largest window.
    set_window(6'd63);
    b = cur_base;
    send_seq(b + 31);
    send_seq(b + 32);
    send_seq(b);
    send_seq(32'd0);

    phase_idx = 0;
    while (n_sent < 1220) begin
      case (phase_idx % 8)
        0: wval = 6'd1;
        1: wval = 6'd32;
        2: wval = 6'd0;
        3: wval = 6'd63;
        4: wval = $urandom_range(2, 8);
        5: wval = $urandom_range(9, 31);
        6: wval = $urandom_range(33, 62);
        default: wval = $urandom_range(2, 32);
      endcase
      set_window(wval);
      idle_on <= ($urandom_range(0, 3) != 0);
      phase_end = n_sent + $urandom_range(60, 200);
      while (n_sent < phase_end) begin
        run_block(1'b1);
        if ($urandom_range(0, 15) == 0) drain();
      end
      // Leave some slots marked ahead so the next window change meets a busy map.
      if (win_eff > 1) begin
        repeat ($urandom_range(1, 4)) send_seq(cur_base + $urandom_range(1, win_eff - 1));
      end
      repeat ($urandom_range(0, 3)) send_seq(noise_seq());
      phase_idx++;
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d transfers over %0d window writes (%0d random phases).",
             n_sent, n_writes, phase_idx);
    $display("Arrivals: in order %0d, ahead %0d, beyond %0d, duplicate %0d.",
             class_cnt[ARR_IN_ORDER], class_cnt[ARR_AHEAD], class_cnt[ARR_BEYOND],
             class_cnt[ARR_DUPLICATE]);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
